/* src/aabb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AABB broad phase package
// Transaction types, stored entry layout and function codes shared by the
// broad phase modules.
// ----------------------------------------------------------------------------
package aabb_pkg;

   localparam logic FUNC_CLEAR = 1'b0;
   localparam logic FUNC_ADD   = 1'b1;

   typedef struct packed {
      logic               func;
      logic        [31:0] entity_id;
      logic signed [31:0] min_x;
      logic signed [31:0] min_y;
      logic signed [31:0] min_z;
      logic signed [31:0] max_x;
      logic signed [31:0] max_y;
      logic signed [31:0] max_z;
      logic        [31:0] layer_bits;
      logic        [31:0] mask_bits;
   } req_type;

   typedef struct packed {
      logic [31:0] earlier_entity;
      logic [31:0] later_entity;
      logic        dropped;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        [31:0] entity;
      logic signed [31:0] min_x;
      logic signed [31:0] min_y;
      logic signed [31:0] min_z;
      logic signed [31:0] max_x;
      logic signed [31:0] max_y;
      logic signed [31:0] max_z;
      logic        [31:0] layer;
      logic        [31:0] mask;
   } entry_type;

endpackage
`default_nettype wire

/* src/aabb_broad_phase_pairs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AABB broad phase pair generator
// A request transaction either clears the box store (a new frame) or adds a
// box. An added box is tested against every stored box in stored order, one
// stored box per cycle through a single pair test unit fed by the store's
// read port, and one response transaction is sent per overlapping pair.
// The last pair of a request carries last. If the store already holds
// MAX_ENTRIES boxes, the box is discarded and one response with dropped and
// last set is sent instead.
// A clear leaves req_stall low. An add keeps req_stall high while it scans
// the store and passes on its pairs. A dropped add keeps req_stall high
// until its dropped response enters the output register. A pair is held
// back until the next hit or the end of the scan shows whether it is last,
// so the final pair is sent as req_stall falls. When rsp_stall is high,
// the scan halts at the next pair that cannot be passed on and resumes
// when the output register drains. Reset empties the store and drops any
// transaction in flight; no clearing pass is needed.
// ----------------------------------------------------------------------------
module aabb_broad_phase_pairs #(
   parameter int MAX_ENTRIES = 64
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  aabb_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output aabb_pkg::rsp_type   rsp_data
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_DROP
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [AW-1:0]       lim_ff, lim_in;
   logic [AW-1:0]       issue_ff, issue_in;
   logic                data_vld_ff, data_vld_in;
   logic                pend_vld_ff, pend_vld_in;
   logic [31:0]         pend_ent_ff, pend_ent_in;
   aabb_pkg::req_type   item_ff, item_in;
   logic                rsp_valid_ff, rsp_valid_in;
   aabb_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic                slot_free;
   logic                push;
   aabb_pkg::rsp_type   push_data;
   logic                wr_en;
   logic                rd_en;
   aabb_pkg::entry_type wr_data;
   aabb_pkg::entry_type rd_data;
   logic                cmp_hit;
   logic                hit;
   logic                advance;

   assign wr_data = '{entity: req_data.entity_id,
                      min_x:  req_data.min_x,
                      min_y:  req_data.min_y,
                      min_z:  req_data.min_z,
                      max_x:  req_data.max_x,
                      max_y:  req_data.max_y,
                      max_z:  req_data.max_z,
                      layer:  req_data.layer_bits,
                      mask:   req_data.mask_bits};

   aabb_store #(
      .DEPTH (MAX_ENTRIES),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (issue_ff),
      .rd_data (rd_data)
   );

   aabb_cmp u_cmp (
      .stored (rd_data),
      .item   (item_ff),
      .hit    (cmp_hit)
   );

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign hit       = data_vld_ff && cmp_hit;
   assign advance   = !hit || !pend_vld_ff || slot_free;

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      lim_in      = lim_ff;
      issue_in    = issue_ff;
      data_vld_in = data_vld_ff;
      pend_vld_in = pend_vld_ff;
      pend_ent_in = pend_ent_ff;
      item_in     = item_ff;
      push        = 1'b0;
      push_data   = '0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               if (req_data.func == aabb_pkg::FUNC_CLEAR) begin
                  cnt_in = '0;
               end else if (cnt_ff == MAX_CNT) begin
                  state_in = ST_DROP;
               end else begin
                  wr_en       = 1'b1;
                  cnt_in      = cnt_ff + 1'b1;
                  lim_in      = cnt_ff[AW-1:0];
                  issue_in    = '0;
                  data_vld_in = 1'b0;
                  pend_vld_in = 1'b0;
                  state_in    = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (advance) begin
               if (hit) begin
                  pend_vld_in = 1'b1;
                  pend_ent_in = rd_data.entity;
                  if (pend_vld_ff) begin
                     push      = 1'b1;
                     push_data = '{earlier_entity: pend_ent_ff,
                                   later_entity:   item_ff.entity_id,
                                   dropped:        1'b0,
                                   last:           1'b0};
                  end
               end
               if (issue_ff != lim_ff) begin
                  rd_en       = 1'b1;
                  issue_in    = issue_ff + 1'b1;
                  data_vld_in = 1'b1;
               end else begin
                  data_vld_in = 1'b0;
                  if (!data_vld_ff) begin
                     state_in = ST_FLUSH;
                  end
               end
            end
         end

         ST_FLUSH: begin
            if (!pend_vld_ff) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               push        = 1'b1;
               push_data   = '{earlier_entity: pend_ent_ff,
                               later_entity:   item_ff.entity_id,
                               dropped:        1'b0,
                               last:           1'b1};
               pend_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end

         ST_DROP: begin
            if (slot_free) begin
               push      = 1'b1;
               push_data = '{earlier_entity: 32'd0,
                             later_entity:   item_ff.entity_id,
                             dropped:        1'b1,
                             last:           1'b1};
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = push_data;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         rsp_data_in  = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         data_vld_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         data_vld_ff  <= data_vld_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lim_ff      <= lim_in;
      issue_ff    <= issue_in;
      pend_ent_ff <= pend_ent_in;
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

/* src/aabb_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AABB box store
// Single write port, single registered read port memory that holds the
// boxes added in the current frame.
// ----------------------------------------------------------------------------
module aabb_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire                   clock,
   input  wire                   wr_en,
   input  wire  [AW-1:0]         wr_addr,
   input  aabb_pkg::entry_type   wr_data,
   input  wire                   rd_en,
   input  wire  [AW-1:0]         rd_addr,
   output aabb_pkg::entry_type   rd_data
);

   aabb_pkg::entry_type mem [DEPTH];
   aabb_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* src/aabb_cmp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AABB pair test unit
// Layer/mask filter (either direction may match) and inclusive signed overlap test on
// all three axes between one stored box and the box being added.
// ----------------------------------------------------------------------------
module aabb_cmp (
   input  aabb_pkg::entry_type stored,
   input  aabb_pkg::req_type   item,
   output logic                hit
);

   logic layer_ok;
   logic ovl_x;
   logic ovl_y;
   logic ovl_z;

   always_comb begin
      layer_ok = ((stored.layer & item.mask_bits) != 32'd0) ||
                 ((item.layer_bits & stored.mask) != 32'd0);
      ovl_x = ($signed(stored.min_x) <= $signed(item.max_x)) &&
              ($signed(item.min_x) <= $signed(stored.max_x));
      ovl_y = ($signed(stored.min_y) <= $signed(item.max_y)) &&
              ($signed(item.min_y) <= $signed(stored.max_y));
      ovl_z = ($signed(stored.min_z) <= $signed(item.max_z)) &&
              ($signed(item.min_z) <= $signed(stored.max_z));
      hit = layer_ok && ovl_x && ovl_y && ovl_z;
   end

endmodule
`default_nettype wire

/* tb/aabb_broad_phase_pairs_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AABB broad phase pair generator testbench
// Drives clear and add transactions into the pair generator with random gaps
// and response stalls, predicts the pair and dropped-entry responses from its
// own copy of the box store, and checks every response in order.
// ----------------------------------------------------------------------------
module aabb_broad_phase_pairs_tb;

   localparam int STORE_DEPTH = 64;
   localparam int HANG_LIMIT  = 5000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   aabb_pkg::req_type    req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   aabb_pkg::rsp_type    rsp_data;

   logic                 quiet = 1'b0;
   aabb_pkg::entry_type  frame_boxes [STORE_DEPTH];
   int                   frame_count = 0;
   aabb_pkg::rsp_type    pair_queue [$];
   logic signed [31:0]   frame_origin [3];
   int unsigned          frame_spread = 16;
   int                   errors = 0;
   int                   adds_sent = 0;
   int                   clears_sent = 0;
   int                   pairs_seen = 0;
   int                   drops_seen = 0;
   int                   hang_cycles = 0;

   aabb_broad_phase_pairs #(
      .MAX_ENTRIES (STORE_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic bit boxes_touch(aabb_pkg::entry_type s, aabb_pkg::req_type r);
      return ($signed(s.min_x) <= $signed(r.max_x)) && ($signed(r.min_x) <= $signed(s.max_x))
          && ($signed(s.min_y) <= $signed(r.max_y)) && ($signed(r.min_y) <= $signed(s.max_y))
          && ($signed(s.min_z) <= $signed(r.max_z)) && ($signed(r.min_z) <= $signed(s.max_z));
   endfunction

   function automatic void expect_rsp(aabb_pkg::rsp_type r);
      pair_queue.insert(pair_queue.size(), r);
   endfunction

   function automatic void predict_pairs(aabb_pkg::req_type r);
      aabb_pkg::rsp_type   held;
      bit                  have_held;
      aabb_pkg::entry_type e;
      have_held = 1'b0;
      if (r.func == aabb_pkg::FUNC_CLEAR) begin
         frame_count = 0;
         return;
      end
      if (frame_count >= STORE_DEPTH) begin
         held.earlier_entity = '0;
         held.later_entity   = r.entity_id;
         held.dropped        = 1'b1;
         held.last           = 1'b1;
         expect_rsp(held);
         return;
      end
      for (int i = 0; i < frame_count; i++) begin
         if (((frame_boxes[i].layer & r.mask_bits) != 0 ||
              (r.layer_bits & frame_boxes[i].mask) != 0) &&
             boxes_touch(frame_boxes[i], r)) begin
            if (have_held) expect_rsp(held);
            held.earlier_entity = frame_boxes[i].entity;
            held.later_entity   = r.entity_id;
            held.dropped        = 1'b0;
            held.last           = 1'b0;
            have_held = 1'b1;
         end
      end
      if (have_held) begin
         held.last = 1'b1;
         expect_rsp(held);
      end
      e.entity = r.entity_id;
      e.min_x  = r.min_x;
      e.min_y  = r.min_y;
      e.min_z  = r.min_z;
      e.max_x  = r.max_x;
      e.max_y  = r.max_y;
      e.max_z  = r.max_z;
      e.layer  = r.layer_bits;
      e.mask   = r.mask_bits;
      frame_boxes[frame_count] = e;
      frame_count++;
   endfunction

   always @(posedge clock) begin
      aabb_pkg::rsp_type want;
      if (!reset && req_valid && !req_stall) predict_pairs(req_data);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pair_queue.size() == 0) begin
            $error("response with none expected: earlier %h later %h dropped %b last %b",
                   rsp_data.earlier_entity, rsp_data.later_entity, rsp_data.dropped,
                   rsp_data.last);
            errors++;
         end else begin
            want = pair_queue.pop_front();
            if (want.dropped) drops_seen++;
            else pairs_seen++;
            if (rsp_data.earlier_entity !== want.earlier_entity) begin
               $error("earlier_entity: expected %h, got %h", want.earlier_entity,
                      rsp_data.earlier_entity);
               errors++;
            end
            if (rsp_data.later_entity !== want.later_entity) begin
               $error("later_entity: expected %h, got %h", want.later_entity,
                      rsp_data.later_entity);
               errors++;
            end
            if (rsp_data.dropped !== want.dropped) begin
               $error("dropped: expected %b, got %b", want.dropped, rsp_data.dropped);
               errors++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_data.last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 30);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         hang_cycles <= 0;
      end else if (hang_cycles >= HANG_LIMIT) begin
         $display("aabb_broad_phase_pairs verification failed");
         $finish;
      end else begin
         hang_cycles <= hang_cycles + 1;
      end
   end

   task automatic send_item(input aabb_pkg::req_type item);
      if (!quiet) begin
         while ($urandom_range(99) < 30) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (item.func == aabb_pkg::FUNC_ADD) adds_sent++;
      else clears_sent++;
   endtask

   function automatic aabb_pkg::req_type add_req(input logic [31:0] ent, mnx, mny, mnz,
                                                 mxx, mxy, mxz, lay, msk);
      aabb_pkg::req_type r;
      r.func       = aabb_pkg::FUNC_ADD;
      r.entity_id  = ent;
      r.min_x      = mnx;
      r.min_y      = mny;
      r.min_z      = mnz;
      r.max_x      = mxx;
      r.max_y      = mxy;
      r.max_z      = mxz;
      r.layer_bits = lay;
      r.mask_bits  = msk;
      return r;
   endfunction

   function automatic aabb_pkg::req_type clear_req();
      aabb_pkg::req_type r;
      r = add_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
      r.func = aabb_pkg::FUNC_CLEAR;
      return r;
   endfunction

   function automatic logic [31:0] pick_layer_word();
      case ($urandom_range(5))
         0: return 32'hFFFF_FFFF;
         1: return 32'h0;
         2: return 32'h1 << $urandom_range(31);
         3: return $urandom;
         default: return $urandom_range(15);
      endcase
   endfunction

   function automatic aabb_pkg::req_type random_add();
      logic [31:0] lo [3];
      logic [31:0] hi [3];
      if ($urandom_range(99) < 15) begin
         foreach (lo[a]) begin
            lo[a] = $urandom;
            hi[a] = $urandom;
         end
      end else begin
         foreach (lo[a]) begin
            lo[a] = frame_origin[a] + $urandom_range(0, frame_spread);
            hi[a] = lo[a] + $urandom_range(0, frame_spread / 2);
         end
      end
      return add_req($urandom, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
                     pick_layer_word(), pick_layer_word());
   endfunction

   task automatic test_pair_rules();
      send_item(clear_req());
      send_item(clear_req());
      send_item(add_req(32'd1, 0, 0, 0, 10, 10, 10, 32'h1, 32'h1));
      send_item(add_req(32'd2, 10, 10, 10, 20, 20, 20, 32'h1, 32'h1));
      send_item(add_req(32'd3, 21, 0, 0, 30, 30, 30, 32'h1, 32'h1));
      send_item(add_req(32'd4, 5, 5, 5, 25, 25, 25, 32'h1, 32'h1));
      send_item(add_req(32'd5, 0, 0, 0, 30, 30, 30, 32'h2, 32'h0));
      send_item(add_req(32'd6, 0, 0, 0, 30, 30, 30, 32'h0, 32'h2));
      send_item(add_req(32'd7, 0, 0, 0, 30, 30, 30, 32'h2, 32'h0));
      send_item(add_req(32'd8, 30, 0, 0, 0, 30, 30, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_item(add_req(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_item(add_req(32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
      send_item(add_req(32'hA5A5_5A5A, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h8000_0000));
      send_item(clear_req());
      send_item(add_req(32'd9, -5, -5, -5, 5, 5, 5, 32'h8000_0000, 32'h8000_0000));
      send_item(add_req(32'd10, 5, 5, 5, 9, 9, 9, 32'h8000_0000, 32'h0));
   endtask

   task automatic test_store_full();
      send_item(clear_req());
      for (int i = 0; i < STORE_DEPTH; i++) begin
         send_item(add_req(32'h1000 + i, i * 4, 0, 0, i * 4 + 1, 1, 1,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF));
      end
      repeat (2) begin
         send_item(add_req($urandom, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF));
      end
      send_item(clear_req());
      send_item(add_req(32'h2000, 0, 0, 0, 8, 8, 8, 32'h4, 32'h4));
      send_item(add_req(32'h2001, 8, 8, 8, 9, 9, 9, 32'h4, 32'h4));
   endtask

   task automatic test_random_frames(input int target);
      int sent;
      int pick;
      int frame_len;
      sent = 0;
      quiet <= 1'b1;
      while (sent < target) begin
         if (sent >= 120) quiet <= 1'b0;
         foreach (frame_origin[a]) frame_origin[a] = $signed($urandom) >>> 2;
         case ($urandom_range(2))
            0: frame_spread = 16;
            1: frame_spread = 32'h0008_0000;
            default: frame_spread = 32'h0100_0000;
         endcase
         send_item(clear_req());
         sent++;
         pick = $urandom_range(99);
         if (pick < 80) frame_len = $urandom_range(1, 24);
         else if (pick < 94) frame_len = $urandom_range(25, STORE_DEPTH - 1);
         else frame_len = $urandom_range(STORE_DEPTH, STORE_DEPTH + 6);
         repeat (frame_len) begin
            send_item(random_add());
            sent++;
         end
      end
      quiet <= 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_pair_rules();
      test_store_full();
      test_random_frames(420);
      req_valid <= 1'b0;
      while (pair_queue.size() != 0) @(posedge clock);
      repeat (STORE_DEPTH + 16) @(posedge clock);
      $display("Sent %0d add and %0d clear transactions under random gaps and stalls.",
               adds_sent, clears_sent);
      $display("Checked %0d pair responses and %0d dropped-entry responses.",
               pairs_seen, drops_seen);
      if (errors == 0) begin
         $display("aabb_broad_phase_pairs verification clean");
      end else begin
         $display("aabb_broad_phase_pairs verification failed");
      end
      $finish;
   end

endmodule
